// ===== src/sai_pkg.sv =====
// sai_pkg: shared constants and types for the sorted array insert/search block
// no dependencies; imported by every module in src
package sai_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  // wide enough to hold the entry count, which reaches CAPACITY itself
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // what one cell hands to its right-hand neighbour
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] data;
    logic                     flag;   // entry sits before the key
  } sai_link_t;

endpackage

// ===== src/sai_cell.sv =====
// sai_cell: one slot of the sorted chain, compares against the key and shifts
// depends on sai_pkg
module sai_cell
  import sai_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cmp_en,
  input  logic                     shift_en,
  input  logic                     op,
  input  logic signed [DATA_W-1:0] key,
  input  sai_link_t                prev,
  output sai_link_t                link,
  output logic                     onehot,
  output logic                     hit
);

  logic                     valid;
  logic signed [DATA_W-1:0] data;
  logic                     flag;
  logic                     eq;
  logic                     ahead;

  // insert goes after equal entries, search stops at the first equal one
  assign ahead = (op == OP_SEARCH) ? (data < key) : (data <= key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      flag  <= 1'b0;
      eq    <= 1'b0;
    end else begin
      if (cmp_en) begin
        flag <= valid & ahead;
        eq   <= valid & (data == key);
      end
      if (shift_en && !flag) begin
        if (prev.flag) begin
          valid <= 1'b1;
          data  <= key;
        end else begin
          valid <= prev.valid;
          data  <= prev.data;
        end
      end
    end
  end

  // first slot whose entry is not before the key
  assign onehot = !flag & prev.flag;
  assign hit    = eq;
  assign link   = '{valid: valid, data: data, flag: flag};

endmodule

// ===== src/sai_pos_enc.sv =====
// sai_pos_enc: turns the boundary marker of the chain into an index and found flag
// depends on sai_pkg
module sai_pos_enc
  import sai_pkg::*;
(
  input  logic [CAPACITY-1:0] onehot,
  input  logic [CAPACITY-1:0] hit,
  output logic [CNT_W-1:0]    index,
  output logic                match
);

  always_comb begin
    index = '0;
    match = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (onehot[i]) begin
        index = index | CNT_W'(i);
      end
      match = match | (onehot[i] & hit[i]);
    end
    // every slot holds an entry before the key
    if (onehot == '0) begin
      index = CNT_W'(CAPACITY);
    end
  end

endmodule

// ===== src/sorted_array_insert_search_top.sv =====
// sequence: a command is registered in ST_IDLE, the cells latch their compare flags in ST_CMP,
// then the cells shift and the result is registered in ST_ACT and shown with done
// a new command is not taken before the last one is through; compare then shift across the cell row
// busy is high in the working states ST_CMP and ST_ACT; the next start is taken while done shows
// reset: rst (synchronous) empties the store and clears the count; the receiver cannot stall
// depends on sai_pkg, sai_cell, sai_pos_enc
module sorted_array_insert_search_top
  import sai_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic signed [DATA_W-1:0] value,
  output logic                     done,
  output logic [POS_W-1:0]         position,
  output logic                     found,
  output logic                     rejected
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_ACT
  } state_t;

  state_t                   state;
  logic                     op_q;
  logic signed [DATA_W-1:0] key_q;
  logic [CNT_W-1:0]         count;

  // cell row wiring: links[i] feeds cell i, links[i+1] comes out of it
  sai_link_t                links [CAPACITY+1];
  logic [CAPACITY-1:0]      onehot;
  logic [CAPACITY-1:0]      hit;
  logic [CAPACITY-1:0]      valid_vec;
  logic [CNT_W-1:0]         index;
  logic                     match;
  logic                     full;
  logic                     shift_en;

  assign busy     = (state != ST_IDLE);
  assign full     = (count == CNT_W'(CAPACITY));
  // store only moves on an accepted insert
  assign shift_en = (state == ST_ACT) && (op_q == OP_INSERT) && !full;

  // left edge of the chain: everything is before the head
  assign links[0] = '{valid: 1'b0, data: '0, flag: 1'b1};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    sai_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmp_en   (state == ST_CMP),
      .shift_en (shift_en),
      .op       (op_q),
      .key      (key_q),
      .prev     (links[g]),
      .link     (links[g+1]),
      .onehot   (onehot[g]),
      .hit      (hit[g])
    );
    assign valid_vec[g] = links[g+1].valid;
  end

  sai_pos_enc u_enc (
    .onehot (onehot),
    .hit    (hit),
    .index  (index),
    .match  (match)
  );

  // control and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            op_q  <= opcode;
            key_q <= value;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          // cells latch their compare flags this cycle
          state <= ST_ACT;
        end
        ST_ACT: begin
          // cells shift, boundary index becomes the result
          done     <= 1'b1;
          position <= POS_W'(index);
          found    <= (op_q == OP_SEARCH) & match;
          rejected <= (op_q == OP_INSERT) & full;
          if (shift_en) begin
            count <= count + CNT_W'(1);
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // a result only follows the shift cycle
  a_done_after_act: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_ACT))
    else $error("done without a preceding shift cycle");

  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // occupied cells match the count
  a_count_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == 32'(count))
    else $error("cell occupancy disagrees with entry count");

  // at most one boundary in the chain during the shift cycle
  a_boundary: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACT) |-> $onehot0(onehot))
    else $error("more than one boundary cell");

endmodule

// ===== tb/testbench.sv =====
// testbench for sorted_array_insert_search_top: ordered inserts and lower-bound searches
// checked against a shadow copy of the sorted store; depends on sai_pkg and the rtl in src
`timescale 1ns / 100ps

module testbench;
  import sai_pkg::*;

  // one result transfer as it appears on the result ports
  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
    logic             rejected;
  } outcome_t;

  // one row of the directed table; pinned rows carry a hand-typed result
  typedef struct packed {
    logic                     opcode;
    logic signed [DATA_W-1:0] value;
    logic                     pinned;
    outcome_t                 outcome;
  } stim_row_t;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_ITEMS   = 1680;
  localparam int QUIET_TAIL     = 250;   // last stretch runs with no idling
  localparam int DRAIN_EVERY    = 400;   // sender waits for all results this often
  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any transfer
  localparam int MAX_PRINTED    = 50;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic                     opcode;
  logic signed [DATA_W-1:0] value;
  logic                     done;
  logic [POS_W-1:0]         position;
  logic                     found;
  logic                     rejected;

  // shadow of the block's state, updated on every accepted command
  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  int                       shadow_count = 0;

  outcome_t pending_results [$];
  logic     pin_valid;
  outcome_t pin_outcome;

  int mismatches  = 0;
  int n_inserts   = 0;
  int n_refused   = 0;
  int n_searches  = 0;
  int n_hits      = 0;
  int idle_cycles = 0;

  sorted_array_insert_search_top uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .value    (value),
    .done     (done),
    .position (position),
    .found    (found),
    .rejected (rejected)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // applies one command to the shadow store and returns the result it gives
  function automatic outcome_t apply_command(logic op, logic signed [DATA_W-1:0] v);
    outcome_t o;
    int       idx;
    int       j;
    o   = '0;
    idx = 0;
    if (op == OP_INSERT) begin
      // stable insert: skip every entry less than or equal to the value
      while (idx < shadow_count && shadow_store[idx] <= v) idx++;
      if (shadow_count >= CAPACITY) begin
        o.rejected = 1'b1;
      end else begin
        for (j = shadow_count; j > idx; j--) shadow_store[j] = shadow_store[j-1];
        shadow_store[idx] = v;
        shadow_count++;
      end
    end else begin
      // lower bound: first entry not less than the value
      while (idx < shadow_count && shadow_store[idx] < v) idx++;
      if (idx < shadow_count && shadow_store[idx] == v) o.found = 1'b1;
    end
    o.position = POS_W'(idx);
    return o;
  endfunction

  function automatic stim_row_t make_row(logic op, logic signed [DATA_W-1:0] v,
                                         int pinned, int pos, int fnd, int rej);
    stim_row_t r;
    r.opcode           = op;
    r.value            = v;
    r.pinned           = (pinned != 0);
    r.outcome.position = POS_W'(pos);
    r.outcome.found    = (fnd != 0);
    r.outcome.rejected = (rej != 0);
    return r;
  endfunction

  // values that hit duplicates, extremes and stored entries often enough to matter
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = $signed($urandom_range(0, 16)) - 8;
      3: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MIN;
          1: v = VAL_MIN + 1;
          2: v = VAL_MAX;
          3: v = VAL_MAX - 1;
          4: v = 0;
          default: v = -1;
        endcase
      end
      4, 5: begin
        // only entries below the count have ever been written
        if (shadow_count > 0) begin
          v = shadow_store[$urandom_range(0, shadow_count - 1)];
          v = v + ($signed($urandom_range(0, 2)) - 1);
        end else begin
          v = $urandom;
        end
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // idle for gap cycles, then present the command until it is transferred
  task automatic issue(input stim_row_t row, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start       <= 1'b1;
    opcode      <= row.opcode;
    value       <= row.value;
    pin_valid   = row.pinned;
    pin_outcome = row.outcome;
    do @(posedge clk); while (!(start === 1'b1 && busy === 1'b0));
  endtask

  // hold the sender off until every result owed has come back
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result checking and command capture, both on the rising edge
  always @(posedge clk) begin : monitor
    outcome_t got;
    outcome_t want;
    outcome_t predicted;
    if (!rst) begin
      // a result transfer is owed to the oldest command still waiting
      if (done === 1'b1) begin
        got.position = position;
        got.found    = found;
        got.rejected = rejected;
        if (pending_results.size() == 0) begin
          note_mismatch("result transfer with no command waiting");
        end else begin
          want = pending_results.pop_front();
          if (got.position !== want.position)
            note_mismatch($sformatf("position got %0d want %0d", got.position, want.position));
          if (got.found !== want.found)
            note_mismatch($sformatf("found got %b want %b", got.found, want.found));
          if (got.rejected !== want.rejected)
            note_mismatch($sformatf("rejected got %b want %b", got.rejected, want.rejected));
        end
      end
      // command transfer: the shadow moves on whether or not the row is pinned
      if (start === 1'b1 && busy === 1'b0) begin
        predicted = apply_command(opcode, value);
        pending_results.push_back(pin_valid ? pin_outcome : predicted);
        if (opcode == OP_INSERT) begin
          n_inserts++;
          if (predicted.rejected) n_refused++;
        end else begin
          n_searches++;
          if (predicted.found) n_hits++;
        end
      end
    end
  end

  // ends a hung run: counts cycles in which neither side transfers anything
  always @(posedge clk) begin
    if (rst || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired after %0d quiet cycles, %0d results outstanding",
               idle_cycles, pending_results.size());
      $display("[sorted_array_insert_search_top] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t rows [$];
    stim_row_t r;
    logic      op;
    int        gap;
    bit        idle_on;
    bit        full;

    rst          = 1'b1;
    start        = 1'b0;
    opcode       = OP_INSERT;
    value        = '0;
    pin_valid    = 1'b0;
    pin_outcome  = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: empty store, extremes, duplicates and the stable order
    rows.push_back(make_row(OP_SEARCH, 0,         1, 0, 0, 0));  // empty store
    rows.push_back(make_row(OP_SEARCH, VAL_MAX,   1, 0, 0, 0));
    rows.push_back(make_row(OP_INSERT, VAL_MIN,   1, 0, 0, 0));
    rows.push_back(make_row(OP_SEARCH, 5,         1, 1, 0, 0));  // past the end
    rows.push_back(make_row(OP_INSERT, VAL_MAX,   1, 1, 0, 0));
    rows.push_back(make_row(OP_INSERT, 0,         1, 1, 0, 0));
    rows.push_back(make_row(OP_INSERT, 0,         1, 2, 0, 0));  // lands after its twin
    rows.push_back(make_row(OP_SEARCH, 0,         1, 1, 1, 0));
    rows.push_back(make_row(OP_SEARCH, VAL_MIN,   1, 0, 1, 0));
    rows.push_back(make_row(OP_SEARCH, VAL_MAX,   1, 3, 1, 0));
    rows.push_back(make_row(OP_SEARCH, VAL_MAX-1, 1, 3, 0, 0));
    rows.push_back(make_row(OP_SEARCH, -1,        1, 1, 0, 0));
    rows.push_back(make_row(OP_INSERT, -1,        1, 1, 0, 0));
    rows.push_back(make_row(OP_INSERT, VAL_MIN,   1, 1, 0, 0));
    rows.push_back(make_row(OP_SEARCH, VAL_MIN+1, 1, 2, 0, 0));
    rows.push_back(make_row(OP_INSERT, VAL_MAX,   1, 6, 0, 0));
    rows.push_back(make_row(OP_SEARCH, VAL_MAX,   1, 5, 1, 0));
    rows.push_back(make_row(OP_INSERT, 32'sh5555_5555, 0, 0, 0, 0));
    rows.push_back(make_row(OP_INSERT, 32'shAAAA_AAAA, 0, 0, 0, 0));
    rows.push_back(make_row(OP_SEARCH, 32'sh5555_5555, 0, 0, 0, 0));
    rows.push_back(make_row(OP_SEARCH, 32'shAAAA_AAAB, 0, 0, 0, 0));

    foreach (rows[i]) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
      issue(rows[i], gap);
    end
    drain();

    // random part: fills the store, then searches it and bounces inserts off it
    idle_on = 1'b1;
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
      full = (shadow_count >= CAPACITY);
      if (!full) op = ($urandom_range(0, 9) < 4) ? OP_INSERT : OP_SEARCH;
      else       op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_SEARCH;
      r = make_row(op, pick_value(), 0, 0, 0, 0);
      gap = 0;
      if (idle_on && k < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 2) == 0)
        gap = $urandom_range(1, 10);
      issue(r, gap);
      if (k % DRAIN_EVERY == DRAIN_EVERY - 1 && k < RANDOM_ITEMS - QUIET_TAIL) drain();
    end

    // let the last results arrive, then watch a little longer for strays
    drain();
    repeat (10) @(posedge clk);

    $display("covered %0d inserts (%0d refused on a full store) and %0d searches (%0d hits)",
             n_inserts, n_refused, n_searches, n_hits);
    $display("store ended with %0d of %0d entries, %0d mismatches",
             shadow_count, CAPACITY, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[sorted_array_insert_search_top] OK");
    end else begin
      $display("[sorted_array_insert_search_top] ERROR");
    end
    $finish;
  end

endmodule
